FILE: rtl/core/bfs_hop_distance_defines.svh
// Assertion macros shared by the hop distance block
`ifndef BFS_HOP_DISTANCE_DEFINES_SVH
`define BFS_HOP_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset
`define BFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset
`define BFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bfs_pkg.sv
// Package: types, constants and codes of the hop distance block
`default_nettype none
package bfs_pkg;

  // Graph size and derived widths
  localparam int NODES   = 32;
  localparam int NodeW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LevelW  = $clog2(NODES + 1);
  localparam int CmdW    = 2;
  localparam int NodeIdW = 5;
  localparam int HopW    = 5;
  localparam int HopMax  = 31;

  typedef logic [NODES-1:0]   node_vec_t;
  typedef logic [NodeIdW-1:0] node_id_t;
  typedef logic [HopW-1:0]    hop_t;
  typedef logic [LevelW-1:0]  level_t;

  // Command codes on the input channel; code 3 is ignored
  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // Operation broadcast to the row of cells
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_CLEAR,
    OP_LOAD,
    OP_STEP
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Control bundle to every cell; node_a carries the source on OP_LOAD
  typedef struct packed {
    cell_op_e op;
    node_id_t node_a;
    node_id_t node_b;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/bfs_stream_if.sv
// Valid/ready channels for command and result transactions
`default_nettype none
interface bfs_cmd_if import bfs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  node_id_t        node_a;
  node_id_t        node_b;

  modport source (output valid, output cmd, output node_a, output node_b, input ready);
  modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

interface bfs_res_if import bfs_pkg::*; ();
  logic valid;
  logic ready;
  hop_t hop_count;
  logic reachable;

  modport source (output valid, output hop_count, output reachable, input ready);
  modport sink   (input valid, input hop_count, input reachable, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bfs_hop_distance.sv
// Hop distance block: edge adds, clear, one breadth-first search per query.
// Add-edge and clear transactions give no result.
// A query searches from node_a, one frontier level per cycle, and reports the
// level at which node_b is reached, or unreachable once the frontier empties.
// The next transaction can be taken in the same cycle as the result is raised; a
// stalled result holds the search. Reset clears rows, search and result state.
`default_nettype none
`include "bfs_hop_distance_defines.svh"
module bfs_hop_distance import bfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfs_cmd_if.sink   in_if,
  bfs_res_if.source out_if
);

  state_e     state_q, state_d;
  node_id_t   dst_q, dst_d;
  level_t     level_q, level_d;
  logic       out_valid_q, out_valid_d;
  hop_t       hop_q, hop_d;
  logic       reach_q, reach_d;
  cell_ctrl_t ctrl;
  node_vec_t  front_vec, seen_vec, one_vec;
  logic [NODES:0] any_chain;
  logic       in_acc, hit, front_any, fin, a_ok, b_ok;

  assign one_vec   = {{(NODES-1){1'b0}}, 1'b1};
  assign any_chain[0] = 1'b0;

  // Row of node cells
  for (genvar g = 0; g < NODES; g++) begin : g_cell
    bfs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (NodeW'(g)),
      .ctrl_i     (ctrl),
      .front_i    (front_vec),
      .any_i      (any_chain[g]),
      .front_o    (front_vec[g]),
      .seen_o     (seen_vec[g]),
      .any_o      (any_chain[g+1])
    );
  end

  assign front_any = any_chain[NODES];
  assign hit       = (int'(dst_q) < NODES) && (|(front_vec & (one_vec << dst_q)));
  assign fin       = hit || !front_any;
  assign in_acc    = in_if.valid && in_if.ready;
  assign a_ok      = int'(in_if.node_a) < NODES;
  assign b_ok      = int'(in_if.node_b) < NODES;

  // Next state, cell control and result register
  always_comb begin
    state_d      = state_q;
    dst_d        = dst_q;
    level_d      = level_q;
    out_valid_d  = out_valid_q;
    hop_d        = hop_q;
    reach_d      = reach_q;
    ctrl.op      = OP_NONE;
    ctrl.node_a  = in_if.node_a;
    ctrl.node_b  = in_if.node_b;
    in_if.ready  = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_if.ready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Ready is always high here, so valid alone marks the transaction
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          priority if (in_if.cmd == CMD_ADD) begin
            if (a_ok && b_ok) ctrl.op = OP_ADD;
          end else if (in_if.cmd == CMD_QUERY) begin
            ctrl.op = OP_LOAD;
            dst_d   = in_if.node_b;
            level_d = '0;
            state_d = ST_SEARCH;
          end else if (in_if.cmd == CMD_CLEAR) begin
            ctrl.op = OP_CLEAR;
          end else begin
            ctrl.op = OP_NONE;
          end
        end
      end
      ST_SEARCH: begin
        if (fin) begin
          // Hold the finished search until the result slot is free
          if (!out_valid_q || out_if.ready) begin
            out_valid_d = 1'b1;
            reach_d     = hit;
            hop_d       = !hit ? '0 :
                          (level_q > LevelW'(HopMax)) ? HopW'(HopMax) : HopW'(level_q);
            state_d     = ST_IDLE;
          end
        end else begin
          ctrl.op = OP_STEP;
          level_d = level_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      dst_q       <= '0;
      hop_q       <= '0;
      reach_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      dst_q       <= dst_d;
      hop_q       <= hop_d;
      reach_q     <= reach_d;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.hop_count = hop_q;
  assign out_if.reachable = reach_q;

  `BFS_ASSERT_NOW(a_result_from_search, $rose(out_valid_q), $past(state_q == ST_SEARCH),
                  "result appeared without a search")
  `BFS_ASSERT_NOW(a_unreach_zero, out_valid_q && !reach_q, hop_q == '0,
                  "unreachable result carries a non-zero hop count")
  `BFS_ASSERT_NOW(a_front_seen, 1'b1, (front_vec & ~seen_vec) == '0,
                  "frontier node not marked visited")
  `BFS_ASSERT_NEXT(a_load_onehot, in_acc && in_if.cmd == CMD_QUERY && a_ok,
                   $onehot(front_vec), "search did not start from a single node")

endmodule
`default_nettype wire

FILE: rtl/core/bfs_cell.sv
// One graph node: adjacency row, frontier and visited bits
`default_nettype none
module bfs_cell import bfs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [NodeW-1:0] cell_idx_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire node_vec_t        front_i,
  input  wire logic             any_i,
  output logic                  front_o,
  output logic                  seen_o,
  output logic                  any_o
);

  node_vec_t row_q, row_d;
  logic      front_q, front_d;
  logic      seen_q, seen_d;
  logic      is_a, is_b, next_bit;
  node_vec_t one_vec;

  assign one_vec = {{(NODES-1){1'b0}}, 1'b1};
  assign is_a    = (int'(cell_idx_i) == int'(ctrl_i.node_a));
  assign is_b    = (int'(cell_idx_i) == int'(ctrl_i.node_b));

  // Row is symmetric, so this node joins the next frontier when any
  // frontier node is a neighbour and it has not been visited
  assign next_bit = (|(row_q & front_i)) & ~seen_q;

  always_comb begin
    row_d   = row_q;
    front_d = front_q;
    seen_d  = seen_q;
    unique case (ctrl_i.op)
      OP_ADD: begin
        if (is_a) row_d = row_d | (one_vec << ctrl_i.node_b);
        if (is_b) row_d = row_d | (one_vec << ctrl_i.node_a);
      end
      OP_CLEAR: row_d = '0;
      OP_LOAD: begin
        front_d = is_a;
        seen_d  = is_a;
      end
      OP_STEP: begin
        front_d = next_bit;
        seen_d  = seen_q | next_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      front_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      row_q   <= row_d;
      front_q <= front_d;
      seen_q  <= seen_d;
    end
  end

  // Pass the frontier-occupied flag on to the next cell
  assign any_o   = any_i | front_q;
  assign front_o = front_q;
  assign seen_o  = seen_q;

endmodule
`default_nettype wire
